### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// opcodes, status codes, sequencer states and distance helper
// ----------------------------------------------------------------------------
package nts_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam int IDX_OUT_W = 12;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PROBE  = 6'b000010,
		ST_FIN_LO = 6'b000100,
		ST_FIN_HI = 6'b001000,
		ST_SEL    = 6'b010000,
		ST_DONE   = 6'b100000
	} nts_state_t;

	// magnitude of the 65-bit difference, both subtractions run in parallel
	function automatic logic [63:0] stamp_dist(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0] d_ab;
		logic [63:0] d_ba;
		d_ab = a - b;
		d_ba = b - a;
		return (a < b) ? d_ba : d_ab;
	endfunction

endpackage

### hw/rtl/nearest_timestamp_search.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_search
// timestamp table with append, clear and binary nearest-match query
// ----------------------------------------------------------------------------
// Items are handled one at a time. Clear, append and unused opcodes go from
// acceptance to the done state, then into the result register once it is
// free. A query on a table of n entries runs one binary-search probe per
// cycle on the table's single read port (at most about log2(n) probes),
// stops at an exact match or else reads the two remaining neighbours and
// compares their distances. The table needs no clearing pass after reset;
// only entries below the fill count are ever read. A result waiting in the
// output register does not keep the block from accepting the next item.
module nearest_timestamp_search
	import nts_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic signed [63:0]          time_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [IDX_OUT_W-1:0]        entry_index
);

	`include "assert_macros.svh"

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

	logic signed [63:0] mem [TABLE_DEPTH];
	logic signed [63:0] rd_data_q;

	nts_state_t         state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      lo_q, hi_q, mid_q;
	logic signed [63:0] t_q;
	logic [63:0]        dist_lo_q, dist_hi_q;
	logic [1:0]         res_status_q;
	logic [AW-1:0]      res_idx_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [IDX_OUT_W-1:0] out_idx_q;

	logic               accept;
	logic               wr_en, rd_en;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      top0, mid0;
	logic               cmp_lt, cmp_gt;
	logic [AW-1:0]      lo_n, hi_n, mid_n;
	logic [AW:0]        sum_n;
	logic               probe_n;
	logic               full;
	logic               out_free;
	logic               out_load;
	logic               in_search;
	logic [63:0]        dist_cur;
	logic [IW-1:0]      res_idx_ext;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign wr_en    = accept && (opcode == OP_APPEND) && !full;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_DONE) && out_free;

	assign top0 = AW'(count_q - CW'(1));
	assign mid0 = top0 >> 1;

	// one probe compare and next bounds
	assign cmp_lt  = (t_q < rd_data_q);
	assign cmp_gt  = (rd_data_q < t_q);
	assign lo_n    = cmp_gt ? mid_q : lo_q;
	assign hi_n    = cmp_lt ? mid_q : hi_q;
	assign sum_n   = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = sum_n[AW:1];
	assign probe_n = (lo_n < hi_n) && (({1'b0, lo_n} + (AW+1)'(1)) != {1'b0, hi_n});

	// one distance unit serves both neighbours in turn
	assign dist_cur = stamp_dist(rd_data_q, t_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_QUERY) && (count_q != '0)) begin
					rd_en   = 1'b1;
					rd_addr = (count_q == CW'(1)) ? '0 : mid0;
				end
			end
			ST_PROBE: begin
				if (cmp_lt || cmp_gt) begin
					rd_en   = 1'b1;
					rd_addr = probe_n ? mid_n : lo_n;
				end
			end
			ST_FIN_LO: begin
				rd_en   = 1'b1;
				rd_addr = hi_q;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= time_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// search bookkeeping, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q          <= time_value;
					lo_q         <= '0;
					hi_q         <= top0;
					mid_q        <= mid0;
					res_status_q <= STAT_OK;
					res_idx_q    <= '0;
					case (opcode)
						OP_APPEND: begin
							if (full) begin
								res_status_q <= STAT_FULL;
							end else begin
								res_idx_q <= count_q[AW-1:0];
							end
						end
						OP_QUERY: begin
							if (count_q == '0) begin
								res_status_q <= STAT_EMPTY;
							end
						end
						default: begin
							res_status_q <= STAT_OK;
						end
					endcase
				end
			end
			ST_PROBE: begin
				lo_q    <= lo_n;
				hi_q    <= hi_n;
				mid_q   <= mid_n;
				if (!cmp_lt && !cmp_gt) begin
					res_idx_q <= mid_q;
				end
			end
			ST_FIN_LO: begin
				dist_lo_q <= dist_cur;
			end
			ST_FIN_HI: begin
				dist_hi_q <= dist_cur;
			end
			ST_SEL: begin
				res_idx_q <= (dist_lo_q > dist_hi_q) ? hi_q : lo_q;
			end
			default: begin
				res_idx_q <= res_idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						if (opcode == OP_CLEAR) begin
							count_q <= '0;
						end
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						if ((opcode == OP_QUERY) && (count_q != '0)) begin
							state_q <= (count_q == CW'(1)) ? ST_FIN_LO : ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (!cmp_lt && !cmp_gt) begin
						state_q <= ST_DONE;
					end else if (!probe_n) begin
						state_q <= ST_FIN_LO;
					end
				end
				ST_FIN_LO: state_q <= ST_FIN_HI;
				ST_FIN_HI: state_q <= ST_SEL;
				ST_SEL:    state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_idx_ext = IW'(res_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_ext[IDX_OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_index = out_idx_q;

	assign in_search = (state_q == ST_PROBE) || (state_q == ST_FIN_LO) ||
		(state_q == ST_FIN_HI);

	// probes and final reads stay in the filled table; output loads go idle
	`ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`ASSERT_IMPLY(a_probe_order, clk, arst_n, state_q == ST_PROBE, lo_q < hi_q)
	`ASSERT_IMPLY(a_hi_in_table, clk, arst_n, in_search, CW'(hi_q) < count_q)
	`ASSERT_NEXT(a_done_release, clk, arst_n, out_load, out_valid && (state_q == ST_IDLE))

endmodule
